// ===== src/mpsm_pkg.sv =====
package mpsm_pkg;

  localparam int MAX_PATTERNS    = 8;
  localparam int MAX_PATTERN_LEN = 32;

  localparam int PIDX_W  = $clog2(MAX_PATTERNS);
  localparam int CPOS_W  = $clog2(MAX_PATTERN_LEN);
  localparam int LEN_W   = CPOS_W + 1;
  localparam int COUNT_W = 4;
  localparam int BYTE_W  = 8;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_PATTERN_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0] PATTERN_COUNT_RST = COUNT_W'(1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_STREAM    = 2'd0,
    OP_LOAD_CHAR = 2'd1,
    OP_LOAD_LEN  = 2'd2,
    OP_RESTART   = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [BYTE_W-1:0] byte_value;
    logic [2:0]        pattern_index;
    logic [4:0]        char_position;
    logic [5:0]        pattern_length;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [2:0] found_index;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] byte_value;
    logic [PIDX_W-1:0] pidx;
    logic [CPOS_W-1:0] cpos;
    logic [LEN_W-1:0]  len;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// ===== src/mpsm_front.sv =====
module mpsm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  mpsm_pkg::in_item_t    in_data,
  output logic                  in_stall,
  input  logic                  pop,
  output mpsm_pkg::queue_head_t head
);
  import mpsm_pkg::*;

  cmd_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  cmd_t              cmd;
  logic              push;
  logic              do_pop;

  always_comb begin
    cmd            = '0;
    cmd.op         = op_t'(in_data.operation);
    cmd.byte_value = in_data.byte_value;
    cmd.pidx       = PIDX_W'(in_data.pattern_index);
    cmd.cpos       = CPOS_W'(in_data.char_position);
    if (in_data.pattern_length > LEN_W'(MAX_PATTERN_LEN)) begin
      cmd.len = LEN_W'(MAX_PATTERN_LEN);
    end else begin
      cmd.len = LEN_W'(in_data.pattern_length);
    end
  end

  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign do_pop   = pop && (count_r != '0);

  assign head.valid = (count_r != '0);
  assign head.cmd   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ===== src/mpsm_back.sv =====
module mpsm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mpsm_pkg::queue_head_t        head,
  output logic                         pop,
  input  logic [mpsm_pkg::COUNT_W-1:0] pattern_count,
  output logic                         out_valid,
  output mpsm_pkg::out_item_t          out_data,
  input  logic                         out_stall
);
  import mpsm_pkg::*;

  logic [BYTE_W-1:0] lane_char [MAX_PATTERNS];
  logic [LEN_W-1:0]  len_r   [MAX_PATTERNS];
  logic [LEN_W-1:0]  len_nxt [MAX_PATTERNS];
  logic [CPOS_W-1:0] pos_r   [MAX_PATTERNS];
  logic [CPOS_W-1:0] pos_nxt [MAX_PATTERNS];
  logic [MAX_PATTERNS-1:0] active;
  logic [MAX_PATTERNS-1:0] hit;
  logic [MAX_PATTERNS-1:0] in_range;
  logic [MAX_PATTERNS-1:0] done;
  logic [MAX_PATTERNS-1:0] blocked;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              slot_free;
  logic              go;
  logic              go_stream;

  assign slot_free = !out_valid_r || !out_stall;
  assign go        = head.valid && ((head.cmd.op != OP_STREAM) || slot_free);
  assign go_stream = go && (head.cmd.op == OP_STREAM);
  assign pop       = go;

  // Each lane keeps its own characters and holds the one at its next position in a register.
  for (genvar g = 0; g < MAX_PATTERNS; g++) begin : g_lane
    logic [BYTE_W-1:0] chars_r [MAX_PATTERN_LEN];
    logic [BYTE_W-1:0] cur_char_r;
    logic              wr_en;

    assign wr_en = go && (head.cmd.op == OP_LOAD_CHAR) && (head.cmd.pidx == PIDX_W'(g));

    always_ff @(posedge clk) begin
      if (wr_en) begin
        chars_r[head.cmd.cpos] <= head.cmd.byte_value;
      end
      if (wr_en && (head.cmd.cpos == pos_nxt[g])) begin
        cur_char_r <= head.cmd.byte_value;
      end else begin
        cur_char_r <= chars_r[pos_nxt[g]];
      end
    end

    assign lane_char[g] = cur_char_r;
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERNS; i++) begin
      active[i]   = (COUNT_W'(i) < pattern_count) && (len_r[i] != '0);
      in_range[i] = {1'b0, pos_r[i]} < len_r[i];
      hit[i]      = active[i] && in_range[i] &&
                    (lane_char[i] == head.cmd.byte_value);
      done[i]     = hit[i] && (({1'b0, pos_r[i]} + 1'b1) == len_r[i]);
    end
    blocked[0] = 1'b0;
    for (int i = 1; i < MAX_PATTERNS; i++) begin
      blocked[i] = blocked[i-1] || done[i-1];
    end
  end

  always_comb begin
    out_data_nxt = '0;
    for (int i = MAX_PATTERNS - 1; i >= 0; i--) begin
      if (done[i]) begin
        out_data_nxt.found       = 1'b1;
        out_data_nxt.found_index = PIDX_W'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PATTERNS; i++) begin
      len_nxt[i] = len_r[i];
      pos_nxt[i] = pos_r[i];
      if (go) begin
        unique case (head.cmd.op)
          OP_STREAM: begin
            if (active[i] && !blocked[i]) begin
              pos_nxt[i] = (hit[i] && !done[i]) ? pos_r[i] + 1'b1 : '0;
            end
          end
          OP_LOAD_LEN: begin
            if (head.cmd.pidx == PIDX_W'(i)) begin
              len_nxt[i] = head.cmd.len;
              pos_nxt[i] = '0;
            end
          end
          OP_RESTART: begin
            if (COUNT_W'(i) < pattern_count) begin
              pos_nxt[i] = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (go_stream) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_PATTERNS; i++) begin
        len_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < MAX_PATTERNS; i++) begin
        len_r[i] <= len_nxt[i];
        pos_r[i] <= pos_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_stream) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/multi_pattern_stream_matcher.sv =====
// Channel   Direction  Moves                         Handshake
// in_       input      one request (op and operands)  in_valid / in_stall
// out_      output     found, found_index             out_valid / out_stall
// config    input      pattern_count at addresses 0-3 psel / penable / pwrite
//
// One request per cycle is sustained while no stream byte waits on out_stall.
// A stream byte's result is registered in out_valid_r and out_data_r when the back end takes it from the queue.
// The per-pattern compare and priority select over eight lanes set the cycle.
// Reset clears positions, lengths, the queue and out_valid; pattern characters and out_data are not reset.
// Loads and restarts proceed while a result waits on out_stall; stream bytes then wait.
module multi_pattern_stream_matcher (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  mpsm_pkg::in_item_t              in_data,
  output logic                            in_stall,
  output logic                            out_valid,
  output mpsm_pkg::out_item_t             out_data,
  input  logic                            out_stall,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mpsm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mpsm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mpsm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import mpsm_pkg::*;

  logic [COUNT_W-1:0] pattern_count_r, pattern_count_nxt;
  queue_head_t        head;
  logic               pop;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1] == REG_PATTERN_COUNT);
  assign prdata  = reg_sel ? CFG_DATA_W'(pattern_count_r) : '0;

  always_comb begin
    pattern_count_nxt = pattern_count_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      pattern_count_nxt = pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_count_r <= PATTERN_COUNT_RST;
    end else begin
      pattern_count_r <= pattern_count_nxt;
    end
  end

  mpsm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .pop      (pop),
    .head     (head)
  );

  mpsm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .pop           (pop),
    .pattern_count (pattern_count_r),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .out_stall     (out_stall)
  );

  a_index_zero_when_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.found_index == '0)
    else $error("found_index is nonzero without a match");

  a_count_after_reset: assert property (@(posedge clk)
    !rst_n |=> pattern_count_r == PATTERN_COUNT_RST)
    else $error("pattern count did not return to its reset value");

  a_idle_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall && !head.valid)
    else $error("datapath not empty after reset");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("back end consumed from an empty queue");

endmodule
